>>> rtl/core/gppd_pkg.sv
`timescale 1ns / 1ps

package gppd_pkg;

  localparam int IN_W      = 12;
  localparam int COORD_MAX = 16;
  localparam int ENT_W     = 32;
  localparam int PT_W      = 62;
  localparam int LIM_BITS  = 60;
  localparam int DIST_W    = 32;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_M00_M01 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_M02_M10 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_M11_M12 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_M20_M21 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_M22_C0  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_C1_C2   = 3'd5;

  typedef struct packed {
    logic [IN_W-1:0] x_start;
    logic [IN_W-1:0] y_start;
    logic [IN_W-1:0] x_end;
    logic [IN_W-1:0] y_end;
  } in_word_t;

  typedef struct packed {
    logic [DIST_W-1:0] ground_distance;
    logic              fault;
  } out_word_t;

  typedef struct packed {
    logic signed [ENT_W-1:0] m00;
    logic signed [ENT_W-1:0] m01;
    logic signed [ENT_W-1:0] m02;
    logic signed [ENT_W-1:0] m10;
    logic signed [ENT_W-1:0] m11;
    logic signed [ENT_W-1:0] m12;
    logic signed [ENT_W-1:0] m20;
    logic signed [ENT_W-1:0] m21;
    logic signed [ENT_W-1:0] m22;
    logic signed [ENT_W-1:0] c0;
    logic signed [ENT_W-1:0] c1;
    logic signed [ENT_W-1:0] c2;
  } cam_t;

  typedef struct packed {
    logic                   vld;
    logic signed [PT_W-1:0] px;
    logic signed [PT_W-1:0] py;
    logic                   fault;
  } point_t;

endpackage

>>> rtl/core/ground_plane_point_distance_unit.sv
`timescale 1ns / 1ps

// channel  | handshake                    | word
// ---------+------------------------------+---------------------------------
// input    | in_valid / in_ready          | in_data  (x_start..y_end)
// output   | out_valid / out_ready        | out_data (ground_distance, fault)
// config   | cfg_we                       | cfg_index, cfg_data
//
// One word per cycle while the output is not stalled; depth is set by the lambda divider
// (32 + FRAC_BITS stages, one quotient bit each) and the 32-stage square root.
// Synchronous reset clears all stage valid bits and the configuration registers.
// Every stage advances together; the whole pipe holds while out_valid waits
// on out_ready, and in_ready falls with it.

module ground_plane_point_distance_unit #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  gppd_pkg::in_word_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output gppd_pkg::out_word_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [gppd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gppd_pkg::CFG_W-1:0]           cfg_data
);

  logic [gppd_pkg::CFG_W-1:0] r_m00_m01;
  logic [gppd_pkg::CFG_W-1:0] r_m02_m10;
  logic [gppd_pkg::CFG_W-1:0] r_m11_m12;
  logic [gppd_pkg::CFG_W-1:0] r_m20_m21;
  logic [gppd_pkg::CFG_W-1:0] r_m22_c0;
  logic [gppd_pkg::CFG_W-1:0] r_c1_c2;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_m00_m01 <= '0;
      r_m02_m10 <= '0;
      r_m11_m12 <= '0;
      r_m20_m21 <= '0;
      r_m22_c0  <= '0;
      r_c1_c2   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        gppd_pkg::REG_M00_M01: r_m00_m01 <= cfg_data;
        gppd_pkg::REG_M02_M10: r_m02_m10 <= cfg_data;
        gppd_pkg::REG_M11_M12: r_m11_m12 <= cfg_data;
        gppd_pkg::REG_M20_M21: r_m20_m21 <= cfg_data;
        gppd_pkg::REG_M22_C0:  r_m22_c0  <= cfg_data;
        gppd_pkg::REG_C1_C2:   r_c1_c2   <= cfg_data;
        default: ;
      endcase
    end
  end

  gppd_pkg::cam_t cam;

  always_comb begin
    cam.m00 = r_m00_m01[63:32];
    cam.m01 = r_m00_m01[31:0];
    cam.m02 = r_m02_m10[63:32];
    cam.m10 = r_m02_m10[31:0];
    cam.m11 = r_m11_m12[63:32];
    cam.m12 = r_m11_m12[31:0];
    cam.m20 = r_m20_m21[63:32];
    cam.m21 = r_m20_m21[31:0];
    cam.m22 = r_m22_c0[63:32];
    cam.c0  = r_m22_c0[31:0];
    cam.c1  = r_c1_c2[63:32];
    cam.c2  = r_c1_c2[31:0];
  end

  logic en;
  logic accept;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign accept   = in_valid && in_ready;

  logic [gppd_pkg::COORD_MAX-1:0] xs_w;
  logic [gppd_pkg::COORD_MAX-1:0] ys_w;
  logic [gppd_pkg::COORD_MAX-1:0] xe_w;
  logic [gppd_pkg::COORD_MAX-1:0] ye_w;

  assign xs_w = gppd_pkg::COORD_MAX'(in_data.x_start);
  assign ys_w = gppd_pkg::COORD_MAX'(in_data.y_start);
  assign xe_w = gppd_pkg::COORD_MAX'(in_data.x_end);
  assign ye_w = gppd_pkg::COORD_MAX'(in_data.y_end);

  gppd_pkg::point_t pt_s;
  gppd_pkg::point_t pt_e;

  gppd_lane #(
    .CB (COORD_BITS),
    .FB (FRAC_BITS)
  ) u_lane_s (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (accept),
    .x      (xs_w[COORD_BITS-1:0]),
    .y      (ys_w[COORD_BITS-1:0]),
    .cam    (cam),
    .pt     (pt_s)
  );

  gppd_lane #(
    .CB (COORD_BITS),
    .FB (FRAC_BITS)
  ) u_lane_e (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (accept),
    .x      (xe_w[COORD_BITS-1:0]),
    .y      (ye_w[COORD_BITS-1:0]),
    .cam    (cam),
    .pt     (pt_e)
  );

  logic        m_vld;
  logic [31:0] m_dist;
  logic        m_fault;

  gppd_merge #(
    .FB (FRAC_BITS)
  ) u_merge (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .pt_s    (pt_s),
    .pt_e    (pt_e),
    .out_vld (m_vld),
    .seg_len (m_dist),
    .fault   (m_fault)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.ground_distance <= m_dist;
      out_data.fault           <= m_fault;
    end
  end

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    pt_s.vld == pt_e.vld)
    else $error("start and end lanes out of step");

  a_fault_saturates: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.fault |-> out_data.ground_distance == '1)
    else $error("fault without saturated distance");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(m_vld) && $stable(pt_s.vld))
    else $error("pipeline moved during stall");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

endmodule

>>> rtl/core/gppd_div.sv
`timescale 1ns / 1ps

module gppd_div #(
  parameter int NW = 56,
  parameter int DW = 47,
  parameter int SW = 98
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side,
  output logic          out_vld,
  output logic [NW-1:0] quo,
  output logic [SW-1:0] out_side
);

  logic [NW:0]   vld;
  logic [DW-1:0] rem   [NW+1];
  logic [NW-1:0] nsh   [NW+1];
  logic [NW-1:0] qacc  [NW+1];
  logic [DW-1:0] dreg  [NW+1];
  logic [SW-1:0] sreg  [NW+1];

  assign vld[0]  = in_vld;
  assign rem[0]  = '0;
  assign nsh[0]  = num;
  assign qacc[0] = '0;
  assign dreg[0] = den;
  assign sreg[0] = side;

  for (genvar g = 0; g < NW; g++) begin : g_stage
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] rem_next;

    always_comb begin
      trial    = {rem[g], nsh[g][NW-1]};
      diff     = trial - {1'b0, dreg[g]};
      ge       = trial >= {1'b0, dreg[g]};
      rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g+1]  <= rem_next;
        nsh[g+1]  <= {nsh[g][NW-2:0], 1'b0};
        qacc[g+1] <= {qacc[g][NW-2:0], ge};
        dreg[g+1] <= dreg[g];
        sreg[g+1] <= sreg[g];
      end
    end
  end

  assign out_vld  = vld[NW];
  assign quo      = qacc[NW];
  assign out_side = sreg[NW];

endmodule

>>> rtl/core/gppd_lane.sv
`timescale 1ns / 1ps

module gppd_lane #(
  parameter int CB = 12,
  parameter int FB = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  logic [CB-1:0]       x,
  input  logic [CB-1:0]       y,
  input  gppd_pkg::cam_t      cam,
  output gppd_pkg::point_t    pt
);

  localparam int PAW = gppd_pkg::ENT_W + CB + 1;
  localparam int ZW  = PAW + 2;
  localparam int NW  = gppd_pkg::ENT_W + FB;
  localparam int PW  = NW + ZW;
  localparam int LL  = NW / 2;
  localparam int ZL  = ZW / 2;
  localparam int SW  = 4 + 2 * ZW;
  localparam int PT  = gppd_pkg::PT_W;
  localparam int LB  = gppd_pkg::LIM_BITS;

  logic signed [CB:0] xs;
  logic signed [CB:0] ys;
  assign xs = signed'({1'b0, x});
  assign ys = signed'({1'b0, y});

  // products
  logic                  a_vld;
  logic signed [PAW-1:0] a_p [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_p[0] <= cam.m00 * xs;
      a_p[1] <= cam.m01 * ys;
      a_p[2] <= cam.m10 * xs;
      a_p[3] <= cam.m11 * ys;
      a_p[4] <= cam.m20 * xs;
      a_p[5] <= cam.m21 * ys;
    end
  end

  // ray direction
  logic                 b_vld;
  logic signed [ZW-1:0] b_z0;
  logic signed [ZW-1:0] b_z1;
  logic signed [ZW-1:0] b_z2;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (en) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_z0 <= ZW'(a_p[0]) + ZW'(a_p[1]) + ZW'(cam.m02);
      b_z1 <= ZW'(a_p[2]) + ZW'(a_p[3]) + ZW'(cam.m12);
      b_z2 <= ZW'(a_p[4]) + ZW'(a_p[5]) + ZW'(cam.m22);
    end
  end

  // magnitudes and signs
  logic              c_vld;
  logic [NW-1:0]     c_num;
  logic [ZW-1:0]     c_den;
  logic [SW-1:0]     c_side;
  logic [31:0]       c2_abs;
  logic [ZW-1:0]     z0_abs;
  logic [ZW-1:0]     z1_abs;
  logic [ZW-1:0]     z2_abs;

  always_comb begin
    c2_abs = cam.c2[31] ? 32'(-cam.c2) : 32'(cam.c2);
    z0_abs = b_z0[ZW-1] ? ZW'(-b_z0) : ZW'(b_z0);
    z1_abs = b_z1[ZW-1] ? ZW'(-b_z1) : ZW'(b_z1);
    z2_abs = b_z2[ZW-1] ? ZW'(-b_z2) : ZW'(b_z2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (en) begin
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_num  <= {c2_abs, {FB{1'b0}}};
      c_den  <= z2_abs;
      c_side <= {(b_z2 == '0), (cam.c2[31] == b_z2[ZW-1]), b_z0[ZW-1], b_z1[ZW-1],
                 z0_abs, z1_abs};
    end
  end

  logic          q_vld;
  logic [NW-1:0] q_lam;
  logic [SW-1:0] q_side;

  gppd_div #(
    .NW (NW),
    .DW (ZW),
    .SW (SW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (c_vld),
    .num      (c_num),
    .den      (c_den),
    .side     (c_side),
    .out_vld  (q_vld),
    .quo      (q_lam),
    .out_side (q_side)
  );

  logic          q_zero;
  logic          q_lneg;
  logic [1:0]    q_zs;
  logic [ZW-1:0] q_zm [2];

  assign q_zero  = q_side[SW-1];
  assign q_lneg  = q_side[SW-2];
  assign q_zs    = q_side[SW-3:SW-4];
  assign q_zm[0] = q_side[2*ZW-1:ZW];
  assign q_zm[1] = q_side[ZW-1:0];

  // partial products of lambda times each axis
  logic                   m1_vld;
  logic                   m1_zero;
  logic [1:0]             m1_neg;
  logic [LL+ZL-1:0]       m1_ll [2];
  logic [NW-LL+ZL-1:0]    m1_hl [2];
  logic [LL+ZW-ZL-1:0]    m1_lh [2];
  logic [NW-LL+ZW-ZL-1:0] m1_hh [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
    end else if (en) begin
      m1_vld <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_zero <= q_zero;
      for (int k = 0; k < 2; k++) begin
        m1_neg[k] <= q_lneg ^ q_zs[1-k];
        m1_ll[k]  <= q_lam[LL-1:0] * q_zm[k][ZL-1:0];
        m1_hl[k]  <= q_lam[NW-1:LL] * q_zm[k][ZL-1:0];
        m1_lh[k]  <= q_lam[LL-1:0] * q_zm[k][ZW-1:ZL];
        m1_hh[k]  <= q_lam[NW-1:LL] * q_zm[k][ZW-1:ZL];
      end
    end
  end

  // full product
  logic          m2_vld;
  logic          m2_zero;
  logic [1:0]    m2_neg;
  logic [PW-1:0] m2_prod [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_vld <= 1'b0;
    end else if (en) begin
      m2_vld <= m1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_zero <= m1_zero;
      m2_neg  <= m1_neg;
      for (int k = 0; k < 2; k++) begin
        m2_prod[k] <= PW'(m1_ll[k]) + (PW'(m1_hl[k]) << LL) + (PW'(m1_lh[k]) << ZL)
                      + (PW'(m1_hh[k]) << (LL + ZL));
      end
    end
  end

  // ground point
  logic [1:0]    ovf;
  logic [LB-1:0] mag [2];
  logic [PT-1:0] off [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      ovf[k] = |m2_prod[k][PW-1:FB+LB];
      mag[k] = m2_prod[k][FB+LB-1:FB];
      off[k] = m2_neg[k] ? PT'(-PT'(mag[k])) : PT'(mag[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pt.vld <= 1'b0;
    end else if (en) begin
      pt.vld <= m2_vld;
    end
    if (en) begin
      pt.px    <= PT'(cam.c0) + signed'(off[0]);
      pt.py    <= PT'(cam.c1) + signed'(off[1]);
      pt.fault <= m2_zero | ovf[0] | ovf[1];
    end
  end

endmodule

>>> rtl/core/gppd_sqrt.sv
`timescale 1ns / 1ps

module gppd_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_vld,
  input  logic [63:0] val,
  input  logic        in_flag,
  output logic        out_vld,
  output logic [31:0] root,
  output logic        out_flag
);

  localparam int NS = 32;

  logic [NS:0]  vld;
  logic [63:0]  vsh  [NS+1];
  logic [33:0]  rem  [NS+1];
  logic [31:0]  racc [NS+1];
  logic [NS:0]  flag;

  assign vld[0]  = in_vld;
  assign vsh[0]  = val;
  assign rem[0]  = '0;
  assign racc[0] = '0;
  assign flag[0] = in_flag;

  for (genvar g = 0; g < NS; g++) begin : g_stage
    logic [33:0] trial_rem;
    logic [33:0] trial;
    logic        ge;

    always_comb begin
      trial_rem = {rem[g][31:0], vsh[g][63:62]};
      trial     = {racc[g], 2'b01};
      ge        = trial_rem >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        vsh[g+1]  <= {vsh[g][61:0], 2'b00};
        rem[g+1]  <= ge ? (trial_rem - trial) : trial_rem;
        racc[g+1] <= {racc[g][30:0], ge};
        flag[g+1] <= flag[g];
      end
    end
  end

  assign out_vld  = vld[NS];
  assign root     = racc[NS];
  assign out_flag = flag[NS];

endmodule

>>> rtl/core/gppd_merge.sv
`timescale 1ns / 1ps

module gppd_merge #(
  parameter int FB = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  gppd_pkg::point_t pt_s,
  input  gppd_pkg::point_t pt_e,
  output logic             out_vld,
  output logic [31:0]      seg_len,
  output logic             fault
);

  localparam int DXW = gppd_pkg::PT_W + 1;

  logic signed [DXW-1:0] dx;
  logic signed [DXW-1:0] dy;
  logic [DXW-1:0]        mx;
  logic [DXW-1:0]        my;

  always_comb begin
    dx = DXW'(pt_s.px) - DXW'(pt_e.px);
    dy = DXW'(pt_s.py) - DXW'(pt_e.py);
    mx = dx[DXW-1] ? DXW'(-dx) : DXW'(dx);
    my = dy[DXW-1] ? DXW'(-dy) : DXW'(dy);
  end

  // truncate to Q16.16
  logic        d1_vld;
  logic        d1_fault;
  logic [31:0] d1_ax;
  logic [31:0] d1_ay;

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_vld <= 1'b0;
    end else if (en) begin
      d1_vld <= pt_s.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_fault <= pt_s.fault | pt_e.fault | (|mx[DXW-1:FB+16]) | (|my[DXW-1:FB+16]);
      d1_ax    <= mx[FB+15:FB-16];
      d1_ay    <= my[FB+15:FB-16];
    end
  end

  // squares
  logic        d2_vld;
  logic        d2_fault;
  logic [63:0] d2_sx;
  logic [63:0] d2_sy;

  always_ff @(posedge clk) begin
    if (rst) begin
      d2_vld <= 1'b0;
    end else if (en) begin
      d2_vld <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_fault <= d1_fault;
      d2_sx    <= 64'(d1_ax) * 64'(d1_ax);
      d2_sy    <= 64'(d1_ay) * 64'(d1_ay);
    end
  end

  // sum
  logic        d3_vld;
  logic        d3_fault;
  logic [63:0] d3_s;
  logic [64:0] sum;

  assign sum = 65'(d2_sx) + 65'(d2_sy);

  always_ff @(posedge clk) begin
    if (rst) begin
      d3_vld <= 1'b0;
    end else if (en) begin
      d3_vld <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d3_fault <= d2_fault | sum[64];
      d3_s     <= sum[63:0];
    end
  end

  logic [31:0] root;

  gppd_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (d3_vld),
    .val      (d3_s),
    .in_flag  (d3_fault),
    .out_vld  (out_vld),
    .root     (root),
    .out_flag (fault)
  );

  assign seg_len = fault ? '1 : root;

endmodule

>>> verif/ground_plane_point_distance_unit_tb.sv
`timescale 1ns / 1ps

module ground_plane_point_distance_unit_tb;

  localparam int FRAC = 24;
  localparam int PIPE_DEPTH = 74 + FRAC;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  gppd_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  gppd_pkg::out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [gppd_pkg::CFG_IDX_W-1:0] cfg_index = gppd_pkg::REG_M00_M01;
  logic [gppd_pkg::CFG_W-1:0] cfg_data = '0;

  logic [63:0] cam_reg [6] = '{default: '0};
  gppd_pkg::in_word_t segment_q [$];
  gppd_pkg::out_word_t distance_q [$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_req = 1'b0;
  logic hold_started = 1'b0;
  int hold_cnt = 0;
  int mismatches = 0;
  int cycles = 0;

  ground_plane_point_distance_unit #(.COORD_BITS(12), .FRAC_BITS(FRAC)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] mag(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint entry(int r, bit hi);
    logic [31:0] u;
    u = hi ? cam_reg[r][63:32] : cam_reg[r][31:0];
    return longint'($signed(u));
  endfunction

  function automatic longint ray_cut(longint c, logic [63:0] lam, logic lneg, longint z,
                                     inout logic ovf);
    logic [127:0] p;
    logic [63:0] m;
    p = ({64'd0, lam} * {64'd0, mag(z)}) >> FRAC;
    m = 0;
    if (p >= (128'd1 << 60)) ovf = 1'b1;
    else m = p[63:0];
    return (lneg != (z < 0)) ? c - longint'(m) : c + longint'(m);
  endfunction

  function automatic logic ground_point(longint x, longint y, output longint px,
                                        output longint py);
    longint z0, z1, z2, c2;
    logic [63:0] lam;
    logic lneg, ovf;
    z0 = entry(0, 1) * x + entry(0, 0) * y + entry(1, 1);
    z1 = entry(1, 0) * x + entry(2, 1) * y + entry(2, 0);
    z2 = entry(3, 1) * x + entry(3, 0) * y + entry(4, 1);
    c2 = entry(5, 0);
    px = 0;
    py = 0;
    ovf = 1'b0;
    if (z2 == 0) return 1'b1;
    lam = (mag(c2) << FRAC) / mag(z2);
    lneg = (c2 < 0) == (z2 < 0);
    px = ray_cut(entry(4, 0), lam, lneg, z0, ovf);
    py = ray_cut(entry(5, 1), lam, lneg, z1, ovf);
    return ovf;
  endfunction

  function automatic gppd_pkg::out_word_t segment_length(gppd_pkg::in_word_t w);
    gppd_pkg::out_word_t r;
    longint psx, psy, pex, pey;
    logic [63:0] ax, ay, t, root;
    logic [64:0] s;
    logic flt;
    flt = ground_point(w.x_start, w.y_start, psx, psy);
    if (!flt) flt = ground_point(w.x_end, w.y_end, pex, pey);
    root = 0;
    if (!flt) begin
      ax = mag(psx - pex) >> (FRAC - 16);
      ay = mag(psy - pey) >> (FRAC - 16);
      if (ax > 64'hFFFFFFFF || ay > 64'hFFFFFFFF) begin
        flt = 1'b1;
      end else begin
        s = {1'b0, ax * ax} + {1'b0, ay * ay};
        if (s[64]) flt = 1'b1;
        for (int i = 31; i >= 0; i--) begin
          t = root | (64'd1 << i);
          if (t * t <= s[63:0]) root = t;
        end
      end
    end
    r.ground_distance = flt ? 32'hFFFFFFFF : root[31:0];
    r.fault = flt;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) distance_q = {distance_q, segment_length(in_data)};
      if (!in_valid || in_ready) begin
        if (segment_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= segment_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    gppd_pkg::out_word_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (distance_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h", out_data);
        end else begin
          want = distance_q.pop_front();
          if (out_data.ground_distance !== want.ground_distance ||
              out_data.fault !== want.fault) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: dist exp %h got %h, fault exp %b got %b",
                       want.ground_distance, out_data.ground_distance,
                       want.fault, out_data.fault);
          end
        end
      end
      if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
        out_ready <= 1'b0;
      end else if (hold_req && !hold_started) begin
        hold_started <= 1'b1;
        hold_cnt <= 400;
        out_ready <= 1'b0;
      end else begin
        out_ready <= $urandom_range(99) >= recv_idle_pct;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(logic [gppd_pkg::CFG_IDX_W-1:0] idx, logic [63:0] d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    cam_reg[idx] = d;
  endtask

  task automatic load_camera(logic [63:0] r0, r1, r2, r3, r4, r5);
    write_reg(gppd_pkg::REG_M00_M01, r0);
    write_reg(gppd_pkg::REG_M02_M10, r1);
    write_reg(gppd_pkg::REG_M11_M12, r2);
    write_reg(gppd_pkg::REG_M20_M21, r3);
    write_reg(gppd_pkg::REG_M22_C0, r4);
    write_reg(gppd_pkg::REG_C1_C2, r5);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_segment(int xs, int ys, int xe, int ye);
    gppd_pkg::in_word_t w;
    w.x_start = 12'(xs);
    w.y_start = 12'(ys);
    w.x_end = 12'(xe);
    w.y_end = 12'(ye);
    segment_q = {segment_q, w};
  endtask

  task automatic drain();
    do @(negedge clk);
    while (segment_q.size() != 0 || in_valid || distance_q.size() != 0);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  function automatic int jitter(int amp);
    return int'($urandom_range(0, 2 * amp)) - amp;
  endfunction

  task automatic random_camera();
    int f, inv, amp, cx, cy;
    int m00, m01, m02, m10, m11, m12, m20, m21, m22, c0, c1, c2;
    f = $urandom_range(200, 3000);
    inv = (1 << FRAC) / f;
    amp = 1 << $urandom_range(0, 14);
    cx = $urandom_range(0, 4095);
    cy = $urandom_range(0, 4095);
    m00 = inv + jitter(amp);
    m01 = jitter(amp);
    m02 = -cx * inv + jitter(amp);
    m10 = jitter(amp);
    m11 = inv + jitter(amp);
    m12 = -cy * inv + jitter(amp);
    m20 = jitter(amp / 4);
    m21 = jitter(amp / 4);
    m22 = -(1 << FRAC) + jitter(amp * 64);
    c0 = jitter(1 << 28);
    c1 = jitter(1 << 28);
    c2 = $urandom_range(1 << 20, 1 << 30);
    if ($urandom_range(7) == 0) c2 = -c2;
    load_camera({m00, m01}, {m02, m10}, {m11, m12}, {m20, m21}, {m22, c0}, {c1, c2});
  endtask

  initial begin
    int inv;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    add_segment(0, 0, 4095, 4095);
    add_segment(100, 200, 300, 400);
    drain();

    inv = (1 << FRAC) / 1000;
    load_camera({inv, 32'sd0}, {-2048 * inv, 32'sd0}, {inv, -2048 * inv},
                {32'sd0, 32'sd0}, {-(32'sd1 << FRAC), 32'sd0}, {32'sd0, 32'sd2 << FRAC});
    add_segment(0, 0, 0, 0);
    add_segment(4095, 4095, 4095, 4095);
    add_segment(0, 0, 4095, 4095);
    add_segment(4095, 0, 0, 4095);
    add_segment(12'hAAA, 12'h555, 12'h555, 12'hAAA);
    add_segment(2048, 2048, 2049, 2048);
    drain();

    load_camera({inv, 32'sd0}, {-2048 * inv, 32'sd0}, {inv, -2048 * inv},
                {32'sd1, -32'sd1}, {32'sd0, 32'sd0}, {32'sd0, 32'sd2 << FRAC});
    add_segment(7, 7, 9, 3);
    add_segment(9, 3, 4095, 4095);
    add_segment(1, 0, 0, 1);
    drain();

    load_camera({32'h7FFFFFFF, 32'h7FFFFFFF}, {32'h7FFFFFFF, 32'h7FFFFFFF},
                {32'h7FFFFFFF, 32'h7FFFFFFF}, {32'sd0, 32'sd0},
                {32'sd1, 32'h7FFFFFFF}, {32'h7FFFFFFF, 32'h7FFFFFFF});
    add_segment(0, 0, 4095, 4095);
    add_segment(4095, 4095, 0, 0);
    drain();

    load_camera({32'sd1 << 24, 32'sd0}, {32'sd0, 32'sd0}, {32'sd1 << 24, 32'sd0},
                {32'sd0, 32'sd0}, {-(32'sd1 << 20), 32'sd0}, {32'sd0, 32'h7F000000});
    add_segment(0, 0, 4095, 4095);
    add_segment(0, 0, 1, 0);
    drain();

    load_camera('1, '1, '1, '1, '1, '1);
    add_segment(0, 0, 4095, 4095);
    add_segment(4095, 0, 0, 4095);
    drain();

    load_camera({2{32'h80000000}}, {2{32'h80000000}}, {2{32'h80000000}},
                {2{32'h80000000}}, {2{32'h80000000}}, {2{32'h80000000}});
    add_segment(0, 0, 4095, 4095);
    add_segment(1, 2, 3, 4);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      send_idle_pct <= (phase < 2) ? 9 : (phase < 4) ? 69 : 0;
      recv_idle_pct <= (phase < 2) ? 69 : (phase < 4) ? 9 : 0;
      if (phase == 5) hold_req <= 1'b1;
      random_camera();
      for (int i = 0; i < 265; i++)
        add_segment($urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 4095), $urandom_range(0, 4095));
      drain();
    end

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
